### rtl/register_alu_instruction_executor_macros.svh
// assertion macros for the register alu instruction executor
// used by the top level only, clocked on clk with active-low rst_n
`ifndef REGISTER_ALU_INSTRUCTION_EXECUTOR_MACROS_SVH
`define REGISTER_ALU_INSTRUCTION_EXECUTOR_MACROS_SVH

// same-cycle implication
`define RAIE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raie assertion failed");

// next-cycle implication
`define RAIE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raie assertion failed");

`endif

### rtl/raie_pkg.sv
// shared widths, opcodes and request codes of the register alu instruction executor
// no dependencies
package raie_pkg;

  localparam int WORD_W    = 32;
  localparam int REG_W     = 3;
  localparam int REQ_W     = 4;
  localparam int CMD_W     = 1;
  localparam int OPC_W     = 4;
  localparam int REG_COUNT = 8;

  localparam logic [CMD_W-1:0] CMD_EXEC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_WB   = 1'b1;

  localparam logic [OPC_W-1:0] OP_CMOV     = 4'd0;
  localparam logic [OPC_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OPC_W-1:0] OP_STORE    = 4'd2;
  localparam logic [OPC_W-1:0] OP_ADD      = 4'd3;
  localparam logic [OPC_W-1:0] OP_MUL      = 4'd4;
  localparam logic [OPC_W-1:0] OP_DIV      = 4'd5;
  localparam logic [OPC_W-1:0] OP_NAND     = 4'd6;
  localparam logic [OPC_W-1:0] OP_HALT     = 4'd7;
  localparam logic [OPC_W-1:0] OP_MAP      = 4'd8;
  localparam logic [OPC_W-1:0] OP_UNMAP    = 4'd9;
  localparam logic [OPC_W-1:0] OP_OUTPUT   = 4'd10;
  localparam logic [OPC_W-1:0] OP_INPUT    = 4'd11;
  localparam logic [OPC_W-1:0] OP_LOADPROG = 4'd12;
  localparam logic [OPC_W-1:0] OP_LOADI    = 4'd13;
  // unassigned opcodes, both answered with a bad-opcode request
  localparam logic [OPC_W-1:0] OP_RSVD_LO  = 4'd14;
  localparam logic [OPC_W-1:0] OP_RSVD_HI  = 4'd15;

  typedef enum logic [REQ_W-1:0] {
    RQ_NONE     = 4'd0,
    RQ_LOAD     = 4'd1,
    RQ_STORE    = 4'd2,
    RQ_MAP      = 4'd3,
    RQ_UNMAP    = 4'd4,
    RQ_OUTPUT   = 4'd5,
    RQ_INPUT    = 4'd6,
    RQ_LOADPROG = 4'd7,
    RQ_HALT     = 4'd8,
    RQ_DIVZERO  = 4'd9,
    RQ_BADOP    = 4'd10
  } request_t;

endpackage

### rtl/raie_if.sv
// valid/ready channel interfaces for instruction items and request items
// depends on raie_pkg
interface raie_in_if;
  import raie_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [WORD_W-1:0] instr_word;
  logic [REG_W-1:0]  wb_reg;
  logic [WORD_W-1:0] wb_value;

  modport source (output valid, command, instr_word, wb_reg, wb_value, input ready);
  modport sink (input valid, command, instr_word, wb_reg, wb_value, output ready);
endinterface

interface raie_out_if;
  import raie_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  request;
  logic [WORD_W-1:0] addr_segment;
  logic [WORD_W-1:0] addr_offset;
  logic [WORD_W-1:0] data_value;
  logic [REG_W-1:0]  target_reg;

  modport source (output valid, request, addr_segment, addr_offset, data_value, target_reg,
                  input ready);
  modport sink (input valid, request, addr_segment, addr_offset, data_value, target_reg,
                output ready);
endinterface

### rtl/raie_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module raie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/register_alu_instruction_executor.sv
// register alu instruction executor of the 32-bit universal machine, top level
// depends on raie_pkg, raie_if, raie_ram and the macros header
//
// Takes one item at a time: in_ch.ready is high only while the sequencer is idle.
// A writeback item goes straight to the register write. An execute item reads r[B], r[C] and r[A] one
// after another through the single read port of the register ram, then executes and
// writes back (no write when a conditional move does not fire); divide first runs the
// radix-2 restoring divider before the write. A request item goes to an output register
// and the block returns to idle; a further request waits only if that register is
// still full. Registers read as zero until first written (a valid bit per register).
module register_alu_instruction_executor #(
  parameter int NUM_REGISTERS = raie_pkg::REG_COUNT
) (
  input logic        clk,
  input logic        rst_n,
  raie_in_if.sink    in_ch,
  raie_out_if.source out_ch
);
  import raie_pkg::*;

  localparam int RIDX_W = $clog2(NUM_REGISTERS);
  localparam int CNT_W  = $clog2(WORD_W);

  typedef enum logic [2:0] {
    S_IDLE, S_RDB, S_RDC, S_RDA, S_EXEC, S_DIV, S_WB, S_EMIT
  } state_t;

  state_t                   state_r;
  logic [WORD_W-1:0]        word_r;
  logic [WORD_W-1:0]        ra_r, rb_r, rc_r;
  logic                     rd_vld_r;
  logic [NUM_REGISTERS-1:0] vld_r;
  logic [RIDX_W-1:0]        wr_addr_r;
  logic [WORD_W-1:0]        wr_data_r;
  logic [WORD_W-1:0]        rem_r, quo_r;
  logic [CNT_W-1:0]         div_cnt_r;

  logic                     out_valid_r;
  logic [REQ_W-1:0]         req_r;
  logic [WORD_W-1:0]        seg_r, off_r, data_r;
  logic [REG_W-1:0]         tgt_r;

  logic [OPC_W-1:0]  opc;
  logic [REG_W-1:0]  fa, fb, fc;
  logic [RIDX_W-1:0] raddr;
  logic [WORD_W-1:0] ram_rdata, rdata_eff;
  logic              ram_we;
  logic              in_acc;
  logic              emit_fire;

  logic [WORD_W:0]   rem_sh, diff;
  logic              ge;
  logic [WORD_W-1:0] rem_nxt, quo_nxt;
  logic [WORD_W-1:0] prod;

  request_t          e_req;
  logic [WORD_W-1:0] e_seg, e_off, e_data;
  logic [REG_W-1:0]  e_tgt;

  assign opc = word_r[31:28];
  assign fa  = word_r[8:6];
  assign fb  = word_r[5:3];
  assign fc  = word_r[2:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign ram_we      = (state_r == S_WB);

  // output register is free now or is emptied at this edge
  assign emit_fire   = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    case (state_r)
      S_RDC:   raddr = RIDX_W'(fc);
      S_RDA:   raddr = RIDX_W'(fa);
      default: raddr = RIDX_W'(fb);
    endcase
  end

  raie_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_REGISTERS)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_r),
    .wdata (wr_data_r),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // never-written registers read as zero
  assign rdata_eff = rd_vld_r ? ram_rdata : '0;

  // one restoring divide step
  assign rem_sh  = {rem_r, quo_r[WORD_W-1]};
  assign diff    = rem_sh - {1'b0, rc_r};
  assign ge      = !diff[WORD_W];
  assign rem_nxt = ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
  assign quo_nxt = {quo_r[WORD_W-2:0], ge};

  assign prod = rb_r * rc_r;

  always_comb begin
    e_req  = RQ_BADOP;
    e_seg  = '0;
    e_off  = '0;
    e_data = '0;
    e_tgt  = '0;
    case (opc)
      OP_LOAD: begin
        e_req = RQ_LOAD;
        e_seg = rb_r;
        e_off = rc_r;
        e_tgt = fa;
      end
      OP_STORE: begin
        e_req  = RQ_STORE;
        e_seg  = ra_r;
        e_off  = rb_r;
        e_data = rc_r;
      end
      OP_DIV:  e_req = RQ_DIVZERO;
      OP_HALT: e_req = RQ_HALT;
      OP_MAP: begin
        e_req  = RQ_MAP;
        e_data = rc_r;
        e_tgt  = fb;
      end
      OP_UNMAP: begin
        e_req = RQ_UNMAP;
        e_seg = rc_r;
      end
      OP_OUTPUT: begin
        e_req  = RQ_OUTPUT;
        e_data = WORD_W'(rc_r[7:0]);
      end
      OP_INPUT: begin
        e_req = RQ_INPUT;
        e_tgt = fc;
      end
      OP_LOADPROG: begin
        e_req = RQ_LOADPROG;
        e_seg = rb_r;
        e_off = rc_r;
      end
      default: e_req = RQ_BADOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            word_r <= in_ch.instr_word;
            if (in_ch.command == CMD_WB) begin
              wr_addr_r <= RIDX_W'(in_ch.wb_reg);
              wr_data_r <= in_ch.wb_value;
              state_r   <= S_WB;
            end else begin
              state_r <= S_RDB;
            end
          end
        end
        S_RDB: state_r <= S_RDC;
        S_RDC: begin
          rb_r    <= rdata_eff;
          state_r <= S_RDA;
        end
        S_RDA: begin
          rc_r    <= rdata_eff;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          ra_r      <= rdata_eff;
          wr_addr_r <= (opc == OP_LOADI) ? RIDX_W'(word_r[27:25]) : RIDX_W'(fa);
          case (opc)
            OP_CMOV: begin
              wr_data_r <= rb_r;
              state_r   <= (rc_r != '0) ? S_WB : S_IDLE;
            end
            OP_ADD: begin
              wr_data_r <= rb_r + rc_r;
              state_r   <= S_WB;
            end
            OP_MUL: begin
              wr_data_r <= prod;
              state_r   <= S_WB;
            end
            OP_NAND: begin
              wr_data_r <= ~(rb_r & rc_r);
              state_r   <= S_WB;
            end
            OP_DIV: begin
              if (rc_r == '0) begin
                state_r <= S_EMIT;
              end else begin
                rem_r     <= '0;
                quo_r     <= rb_r;
                div_cnt_r <= CNT_W'(WORD_W - 1);
                state_r   <= S_DIV;
              end
            end
            OP_LOADI: begin
              wr_data_r <= WORD_W'(word_r[24:0]);
              state_r   <= S_WB;
            end
            default: state_r <= S_EMIT;
          endcase
        end
        S_DIV: begin
          rem_r     <= rem_nxt;
          quo_r     <= quo_nxt;
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) begin
            wr_data_r <= quo_nxt;
            state_r   <= S_WB;
          end
        end
        S_WB: begin
          vld_r[wr_addr_r] <= 1'b1;
          state_r          <= S_IDLE;
        end
        S_EMIT: begin
          // wait for the output register to be free
          if (emit_fire) begin
            req_r   <= e_req;
            seg_r   <= e_seg;
            off_r   <= e_off;
            data_r  <= e_data;
            tgt_r   <= e_tgt;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.request      = req_r;
  assign out_ch.addr_segment = seg_r;
  assign out_ch.addr_offset  = off_r;
  assign out_ch.data_value   = data_r;
  assign out_ch.target_reg   = tgt_r;

`include "register_alu_instruction_executor_macros.svh"

  `RAIE_ASSERT_NEXT(a_wb_item_writes, in_acc && in_ch.command == CMD_WB, state_r == S_WB)
  `RAIE_ASSERT_NEXT(a_div_starts, state_r == S_EXEC && opc == OP_DIV && rc_r != '0, state_r == S_DIV)
  `RAIE_ASSERT_NEXT(a_div_counts, state_r == S_DIV && div_cnt_r != '0, state_r == S_DIV && div_cnt_r == $past(div_cnt_r) - 1'b1)
  `RAIE_ASSERT_NEXT(a_write_marks_valid, state_r == S_WB, vld_r[$past(wr_addr_r)] && state_r == S_IDLE)

endmodule
